/* src/gsa_pkg.sv */
// gsa_pkg: shared field widths, command and status codes, result beat type
// used by the slot allocator interfaces and modules; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package gsa_pkg;

    localparam int CMD_W  = 2;
    localparam int ID_W   = 6;
    localparam int HGEN_W = 16;
    localparam int ST_W   = 2;

    localparam int NUM_SLOTS_DEF = 64;
    localparam int GEN_WIDTH_DEF = 16;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_STALE     = 2'd1;
    localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd2;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [ID_W-1:0]   granted_id;
        logic [HGEN_W-1:0] granted_generation;
    } t_result;

endpackage

`default_nettype wire

/* src/gsa_if.sv */
// gsa_cmd_if and gsa_res_if: valid/ready channels for command and result beats
// depends on gsa_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface gsa_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [gsa_pkg::CMD_W-1:0]   command;
    logic [gsa_pkg::ID_W-1:0]    slot_id;
    logic [gsa_pkg::HGEN_W-1:0]  handle_generation;

    modport source (output valid, command, slot_id, handle_generation, input ready);
    modport sink   (input valid, command, slot_id, handle_generation, output ready);
endinterface

interface gsa_res_if;
    logic                        valid;
    logic                        ready;
    logic [gsa_pkg::ST_W-1:0]    status;
    logic [gsa_pkg::ID_W-1:0]    granted_id;
    logic [gsa_pkg::HGEN_W-1:0]  granted_generation;

    modport source (output valid, status, granted_id, granted_generation, input ready);
    modport sink   (input valid, status, granted_id, granted_generation, output ready);
endinterface

`default_nettype wire

/* src/generational_slot_allocator_core.sv */
// latency: a result beat is offered on the edge after its command beat is taken, unless the
// result register still holds a beat that the sink has not taken
// throughput: one command per cycle unless the output stalls; slot entry read-modify-write,
// free-head pop/push and open count update all close in the single execute stage
// reset: free list empty, no slots opened, pipeline and result register empty;
// the slot memory is not cleared, entries are written when a slot is first opened
// generational_slot_allocator_core: top level; uses gsa_pkg, gsa_if, gsa_slot_table,
// gsa_result_reg
`timescale 1ns / 1ps
`default_nettype none

module generational_slot_allocator_core #(
    parameter int NUM_SLOTS = gsa_pkg::NUM_SLOTS_DEF,
    parameter int GEN_WIDTH = gsa_pkg::GEN_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gsa_cmd_if.sink   i_cmd,
    gsa_res_if.source o_res
);

    localparam int IDX_W   = $clog2(NUM_SLOTS);
    localparam int PTR_W   = $clog2(NUM_SLOTS + 1);
    localparam int ENTRY_W = 2 + GEN_WIDTH + PTR_W;
    localparam int CMP_W   = (gsa_pkg::ID_W > PTR_W) ? gsa_pkg::ID_W : PTR_W;
    localparam int GCMP_W  = (gsa_pkg::HGEN_W > GEN_WIDTH) ? gsa_pkg::HGEN_W : GEN_WIDTH;

    localparam logic [PTR_W-1:0]     EMPTY   = PTR_W'(NUM_SLOTS);
    localparam logic [GEN_WIDTH-1:0] GEN_MAX = '1;

    // execute stage
    logic                             r_busy;
    logic [gsa_pkg::CMD_W-1:0]        r_cmd;
    logic [gsa_pkg::ID_W-1:0]         r_id;
    logic [gsa_pkg::HGEN_W-1:0]       r_hgen;
    logic [PTR_W-1:0]                 r_free_head;
    logic [PTR_W-1:0]                 r_slots_opened;
    logic [PTR_W-1:0]                 n_free_head;
    logic [PTR_W-1:0]                 n_slots_opened;

    logic                             in_accept;
    logic                             s1_adv;
    logic                             out_free;
    logic [IDX_W-1:0]                 rd_addr;

    logic [ENTRY_W-1:0]               ent;
    logic                             e_retired;
    logic                             e_live;
    logic [GEN_WIDTH-1:0]             e_gen;
    logic [PTR_W-1:0]                 e_link;
    logic                             hit;

    logic [PTR_W-1:0]                 s1_free_head;
    logic [PTR_W-1:0]                 s1_opened;
    logic                             s1_we;
    logic [IDX_W-1:0]                 s1_waddr;
    logic                             w_retired;
    logic                             w_live;
    logic [GEN_WIDTH-1:0]             w_gen;
    logic [PTR_W-1:0]                 w_link;
    logic                             g_ok;
    logic [IDX_W-1:0]                 g_addr;
    logic                             b_retired;
    logic [GEN_WIDTH-1:0]             b_gen;
    gsa_pkg::t_result                 res;

    assign in_accept   = i_cmd.valid && i_cmd.ready;
    assign s1_adv      = r_busy && out_free;
    assign i_cmd.ready = !r_busy || s1_adv;

    assign n_free_head    = s1_adv ? s1_free_head : r_free_head;
    assign n_slots_opened = s1_adv ? s1_opened : r_slots_opened;

    // read address: head after the item in execute commits, or the handle's slot
    always_comb begin
        if (i_cmd.command == gsa_pkg::CMD_ALLOC) begin
            rd_addr = (n_free_head < EMPTY) ? n_free_head[IDX_W-1:0] : '0;
        end else begin
            rd_addr = IDX_W'(i_cmd.slot_id);
        end
    end

    gsa_slot_table #(
        .IDX_W   (IDX_W),
        .ENTRY_W (ENTRY_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_accept),
        .i_rd_addr (rd_addr),
        .i_wr_en   (s1_we && s1_adv),
        .i_wr_addr (s1_waddr),
        .i_wr_data ({w_retired, w_live, w_gen, w_link}),
        .o_rd_data (ent)
    );

    assign e_retired = ent[ENTRY_W-1];
    assign e_live    = ent[ENTRY_W-2];
    assign e_gen     = ent[PTR_W +: GEN_WIDTH];
    assign e_link    = ent[PTR_W-1:0];

    assign hit = (CMP_W'(r_id) < CMP_W'(r_slots_opened)) && e_live
              && (GCMP_W'(e_gen) == GCMP_W'(r_hgen));

    always_comb begin
        s1_free_head = r_free_head;
        s1_opened    = r_slots_opened;
        s1_we        = 1'b0;
        s1_waddr     = IDX_W'(r_id);
        w_retired    = e_retired;
        w_live       = e_live;
        w_gen        = e_gen;
        w_link       = e_link;
        g_ok         = 1'b0;
        g_addr       = '0;
        b_retired    = 1'b0;
        b_gen        = '0;
        res.status             = gsa_pkg::ST_STALE;
        res.granted_id         = r_id;
        res.granted_generation = '0;
        case (r_cmd)
            gsa_pkg::CMD_ALLOC: begin
                res.granted_id = '0;
                if (r_free_head < EMPTY) begin
                    g_ok         = 1'b1;
                    g_addr       = r_free_head[IDX_W-1:0];
                    b_retired    = e_retired;
                    b_gen        = e_gen;
                    s1_free_head = (e_link > EMPTY) ? EMPTY : e_link;
                end else if (r_slots_opened < EMPTY) begin
                    g_ok      = 1'b1;
                    g_addr    = r_slots_opened[IDX_W-1:0];
                    s1_opened = r_slots_opened + 1'b1;
                end
                res.status = gsa_pkg::ST_EXHAUSTED;
                if (g_ok) begin
                    s1_we     = 1'b1;
                    s1_waddr  = g_addr;
                    w_link    = EMPTY;
                    w_retired = b_retired;
                    if (b_retired || (b_gen == GEN_MAX)) begin
                        w_live = 1'b0;
                        w_gen  = b_gen;
                    end else begin
                        w_live                 = 1'b1;
                        w_gen                  = b_gen + 1'b1;
                        res.status             = gsa_pkg::ST_OK;
                        res.granted_id         = gsa_pkg::ID_W'(g_addr);
                        res.granted_generation = gsa_pkg::HGEN_W'(w_gen);
                    end
                end
            end
            gsa_pkg::CMD_RELEASE: begin
                if (hit) begin
                    s1_we      = 1'b1;
                    w_live     = 1'b0;
                    res.status = gsa_pkg::ST_OK;
                    if (e_gen == GEN_MAX) begin
                        w_retired = 1'b1;
                        w_link    = EMPTY;
                    end else begin
                        w_link       = r_free_head;
                        s1_free_head = PTR_W'(s1_waddr);
                    end
                end
            end
            gsa_pkg::CMD_CHECK: begin
                res.status = hit ? gsa_pkg::ST_OK : gsa_pkg::ST_STALE;
            end
            default: begin
                res.status = gsa_pkg::ST_STALE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy         <= 1'b0;
            r_free_head    <= EMPTY;
            r_slots_opened <= '0;
        end else begin
            r_free_head    <= n_free_head;
            r_slots_opened <= n_slots_opened;
            if (in_accept) begin
                r_busy <= 1'b1;
            end else if (s1_adv) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd  <= i_cmd.command;
            r_id   <= i_cmd.slot_id;
            r_hgen <= i_cmd.handle_generation;
        end
    end

    gsa_result_reg u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s1_adv),
        .i_res   (res),
        .o_free  (out_free),
        .o_res   (o_res)
    );

`ifndef SYNTHESIS
    // free list only ever holds opened slots
    a_head_opened: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free_head != EMPTY) |-> (r_free_head < r_slots_opened))
        else $error("free head points past opened slots");

    // a stalled item leaves allocator state untouched
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !s1_adv) |=> ($stable(r_free_head) && $stable(r_slots_opened)))
        else $error("allocator state changed while execute stage stalled");

    // slots open one at a time
    a_open_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slots_opened != EMPTY) |=> ((r_slots_opened == $past(r_slots_opened))
            || (r_slots_opened == $past(r_slots_opened) + 1'b1)))
        else $error("open count jumped");
`endif

endmodule

`default_nettype wire

/* src/gsa_slot_table.sv */
// gsa_slot_table: per-slot entry memory, one write and one registered read port,
// with write-to-read forwarding for a same-address access; no package use
`timescale 1ns / 1ps
`default_nettype none

module gsa_slot_table #(
    parameter int IDX_W   = 6,
    parameter int ENTRY_W = 25
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_rd_en,
    input  wire logic [IDX_W-1:0]   i_rd_addr,
    input  wire logic               i_wr_en,
    input  wire logic [IDX_W-1:0]   i_wr_addr,
    input  wire logic [ENTRY_W-1:0] i_wr_data,
    output logic      [ENTRY_W-1:0] o_rd_data
);

    localparam int DEPTH = 1 << IDX_W;

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_mem_q;
    logic               r_byp;
    logic [ENTRY_W-1:0] r_byp_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_mem_q    <= r_mem[i_rd_addr];
            r_byp_data <= i_wr_data;
        end
    end

    // same-cycle write to the address being read wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (i_rd_en) begin
            r_byp <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : r_mem_q;

endmodule

`default_nettype wire

/* src/gsa_result_reg.sv */
// gsa_result_reg: output register holding one result beat toward the sink
// depends on gsa_pkg (t_result) and gsa_res_if
`timescale 1ns / 1ps
`default_nettype none

module gsa_result_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire gsa_pkg::t_result i_res,
    output logic                  o_free,
    gsa_res_if.source             o_res
);

    logic             r_vld;
    gsa_pkg::t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_free                   = !r_vld || o_res.ready;
    assign o_res.valid              = r_vld;
    assign o_res.status             = r_res.status;
    assign o_res.granted_id         = r_res.granted_id;
    assign o_res.granted_generation = r_res.granted_generation;

endmodule

`default_nettype wire

/* tb/gsa_checker.sv */
// gsa_checker: watches the command and result channels of the slot allocator,
// predicts every result beat from its own copy of the slot table and compares field by field
// depends on gsa_pkg, gsa_cmd_if and gsa_res_if
`timescale 1ns / 1ps

module gsa_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gsa_cmd_if        i_cmd,
    gsa_res_if        i_res,
    output int        o_fail_count,
    output int        o_pending
);
    import gsa_pkg::*;

    localparam int SLOTS = NUM_SLOTS_DEF;
    localparam logic [ID_W:0] LIST_END = (ID_W + 1)'(SLOTS);
    localparam logic [HGEN_W-1:0] GEN_TOP = '1;

    logic [HGEN_W-1:0] gen_tab [SLOTS];
    logic              live_tab [SLOTS];
    logic              retired_tab [SLOTS];
    logic [ID_W:0]     link_tab [SLOTS];
    logic [ID_W:0]     free_top;
    logic [ID_W:0]     open_cnt;

    t_result grant_q [$];
    t_result want;

    function automatic void clear_table();
        for (int i = 0; i < SLOTS; i++) begin
            gen_tab[i] = '0;
            live_tab[i] = 1'b0;
            retired_tab[i] = 1'b0;
            link_tab[i] = '0;
        end
        free_top = LIST_END;
        open_cnt = '0;
    endfunction

    function automatic t_result step_table(input logic [CMD_W-1:0] cmd,
                                           input logic [ID_W-1:0] id,
                                           input logic [HGEN_W-1:0] hgen);
        t_result r;
        logic [ID_W:0] pick;
        logic got;
        logic hit;
        r.status = ST_STALE;
        r.granted_id = id;
        r.granted_generation = '0;
        got = 1'b0;
        pick = '0;
        hit = ({1'b0, id} < open_cnt) && live_tab[id] && (gen_tab[id] == hgen);
        case (cmd)
            CMD_ALLOC: begin
                if (free_top < LIST_END) begin
                    pick = free_top;
                    free_top = link_tab[pick[ID_W-1:0]];
                    got = 1'b1;
                end else if (open_cnt < LIST_END) begin
                    pick = open_cnt;
                    open_cnt = open_cnt + 1'b1;
                    gen_tab[pick[ID_W-1:0]] = '0;
                    live_tab[pick[ID_W-1:0]] = 1'b0;
                    retired_tab[pick[ID_W-1:0]] = 1'b0;
                    got = 1'b1;
                end
                r.status = ST_EXHAUSTED;
                r.granted_id = '0;
                if (got) begin
                    link_tab[pick[ID_W-1:0]] = LIST_END;
                    if (retired_tab[pick[ID_W-1:0]] || gen_tab[pick[ID_W-1:0]] == GEN_TOP) begin
                        live_tab[pick[ID_W-1:0]] = 1'b0;
                    end else begin
                        gen_tab[pick[ID_W-1:0]] = gen_tab[pick[ID_W-1:0]] + 1'b1;
                        live_tab[pick[ID_W-1:0]] = 1'b1;
                        r.status = ST_OK;
                        r.granted_id = pick[ID_W-1:0];
                        r.granted_generation = gen_tab[pick[ID_W-1:0]];
                    end
                end
            end
            CMD_RELEASE: begin
                if (hit) begin
                    live_tab[id] = 1'b0;
                    if (gen_tab[id] == GEN_TOP) begin
                        retired_tab[id] = 1'b1;
                        link_tab[id] = LIST_END;
                    end else begin
                        link_tab[id] = free_top;
                        free_top = {1'b0, id};
                    end
                    r.status = ST_OK;
                end
            end
            CMD_CHECK: begin
                if (hit)
                    r.status = ST_OK;
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_table();
            grant_q.delete();
            o_fail_count = 0;
            o_pending = 0;
        end else begin
            if (i_cmd.valid && i_cmd.ready)
                grant_q.insert(grant_q.size(), step_table(i_cmd.command, i_cmd.slot_id,
                                                          i_cmd.handle_generation));
            if (i_res.valid && i_res.ready) begin
                if (grant_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    o_fail_count++;
                end else begin
                    want = grant_q.pop_front();
                    if (i_res.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_res.status);
                        o_fail_count++;
                    end
                    if (i_res.granted_id !== want.granted_id) begin
                        $error("granted_id: expected %0d, got %0d",
                               want.granted_id, i_res.granted_id);
                        o_fail_count++;
                    end
                    if (i_res.granted_generation !== want.granted_generation) begin
                        $error("granted_generation: expected %0d, got %0d",
                               want.granted_generation, i_res.granted_generation);
                        o_fail_count++;
                    end
                end
            end
            o_pending = grant_q.size();
        end
    end

endmodule

/* tb/generational_slot_allocator_core_test.sv */
// generational_slot_allocator_core_test: clock, reset and command stimulus for the slot
// allocator, with random idling on both channels; gsa_checker does all the comparing
// depends on gsa_pkg, gsa_if, generational_slot_allocator_core and gsa_checker
`timescale 1ns / 1ps

module generational_slot_allocator_core_test;
    import gsa_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [HGEN_W-1:0] gen;
    } t_slot_ref;

    localparam int RANDOM_BEATS = 950;
    localparam logic [CMD_W-1:0] CMD_UNDEF = 2'd3;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;

    gsa_cmd_if cmd_if ();
    gsa_res_if res_if ();

    generational_slot_allocator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    gsa_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    int               sent_cnt = 0;
    int               recv_cnt = 0;
    logic             calm = 1'b0;
    logic             track = 1'b0;
    logic [CMD_W-1:0] kind_q [$];
    t_slot_ref        live_pool [$];
    t_slot_ref        dead_pool [$];
    t_slot_ref        last_grant = '0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #60000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            res_if.ready <= i_rst_n && (calm || $urandom_range(0, 99) >= 35);
        end
    end

    // learn granted slots from the result beats
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            recv_cnt++;
            if (kind_q.size() != 0) begin
                if (kind_q.pop_front() == CMD_ALLOC && res_if.status == ST_OK) begin
                    last_grant = {res_if.granted_id, res_if.granted_generation};
                    if (track)
                        live_pool.insert(live_pool.size(), last_grant);
                end
            end
        end
    end

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                            input logic [HGEN_W-1:0] hgen);
        while (!calm && $urandom_range(0, 99) < 35) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.command <= cmd;
        cmd_if.slot_id <= id;
        cmd_if.handle_generation <= hgen;
        @(posedge i_clk);
        while (!cmd_if.ready)
            @(posedge i_clk);
        kind_q.insert(kind_q.size(), cmd);
        sent_cnt++;
    endtask

    task automatic drain();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (recv_cnt != sent_cnt)
            @(posedge i_clk);
    endtask

    task automatic send_random(input int alloc_pct);
        int        pick;
        int        idx;
        t_slot_ref h;
        logic      bent;
        logic [CMD_W-1:0] cmd;
        pick = $urandom_range(0, 99);
        if (pick < alloc_pct) begin
            send_cmd(CMD_ALLOC, ID_W'($urandom_range(0, 63)), HGEN_W'($urandom()));
        end else if (pick > 96) begin
            send_cmd(CMD_UNDEF, ID_W'($urandom_range(0, 63)), HGEN_W'($urandom()));
        end else begin
            cmd = ($urandom_range(0, 1) == 0) ? CMD_RELEASE : CMD_CHECK;
            pick = $urandom_range(0, 99);
            bent = 1'b0;
            if (live_pool.size() != 0 && pick < 75) begin
                idx = $urandom_range(0, live_pool.size() - 1);
                h = live_pool[idx];
                if ($urandom_range(0, 99) < 15) begin
                    h.gen = h.gen ^ (16'd1 << $urandom_range(0, 15));
                    bent = 1'b1;
                end
                if (cmd == CMD_RELEASE && !bent) begin
                    live_pool.delete(idx);
                    dead_pool.insert(dead_pool.size(), h);
                    if (dead_pool.size() > 16)
                        void'(dead_pool.pop_front());
                end
            end else if (dead_pool.size() != 0 && pick < 88) begin
                h = dead_pool[$urandom_range(0, dead_pool.size() - 1)];
            end else begin
                h = {6'($urandom_range(0, 63)), 16'($urandom())};
            end
            send_cmd(cmd, h.id, h.gen);
        end
    endtask

    initial begin
        int        alloc_pct;
        i_rst_n = 1'b0;
        cmd_if.valid <= 1'b0;
        cmd_if.command <= CMD_ALLOC;
        cmd_if.slot_id <= '0;
        cmd_if.handle_generation <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unopened slots, then a few opens and every stale case
        send_cmd(CMD_CHECK, 6'd0, 16'd0);
        send_cmd(CMD_RELEASE, 6'd63, 16'hFFFF);
        send_cmd(CMD_ALLOC, 6'd63, 16'hFFFF);
        send_cmd(CMD_ALLOC, 6'd0, 16'd0);
        send_cmd(CMD_ALLOC, 6'd21, 16'h5555);
        send_cmd(CMD_CHECK, 6'd0, 16'd1);
        send_cmd(CMD_CHECK, 6'd0, 16'd0);
        send_cmd(CMD_CHECK, 6'd1, 16'hFFFF);
        send_cmd(CMD_CHECK, 6'd3, 16'd1);
        send_cmd(CMD_RELEASE, 6'd1, 16'd2);
        send_cmd(CMD_RELEASE, 6'd1, 16'd1);
        send_cmd(CMD_RELEASE, 6'd1, 16'd1);
        send_cmd(CMD_CHECK, 6'd1, 16'd1);
        send_cmd(CMD_ALLOC, 6'd42, 16'hAAAA);
        send_cmd(CMD_CHECK, 6'd1, 16'd2);
        send_cmd(CMD_UNDEF, 6'd63, 16'hFFFF);
        send_cmd(CMD_UNDEF, 6'd0, 16'd0);
        send_cmd(CMD_RELEASE, 6'd2, 16'd1);
        send_cmd(CMD_RELEASE, 6'd0, 16'd1);
        send_cmd(CMD_ALLOC, 6'd0, 16'd0);
        send_cmd(CMD_ALLOC, 6'd0, 16'd0);
        send_cmd(CMD_ALLOC, 6'd0, 16'd0);

        // hold off until everything is back
        drain();

        track = 1'b1;
        for (int i = 0; i < RANDOM_BEATS; i++) begin
            calm = (i >= 350 && i < 500);
            if (i >= 100 && i < 180)
                alloc_pct = 100;
            else
                alloc_pct = ((i / 60) % 2 == 1) ? 25 : 70;
            send_random(alloc_pct);
        end
        calm = 1'b0;

        drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
